FILE: sv/int_to_roman_encoder_unit_defines.svh
// Assertion macros for the checker file.
`ifndef INT_TO_ROMAN_ENCODER_UNIT_DEFINES_SVH
`define INT_TO_ROMAN_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ROMAN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ROMAN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/roman_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package roman_pkg;

    // Field widths
    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 8;

    // Largest value that has a standard numeral
    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // Greedy table: M CM D CD C XC L XL X IX V IV I
    localparam int NUM_ENTRIES = 13;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // ASCII symbols
    localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
    localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
    localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
    localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
    localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4D;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SECOND
    } t_state;

    // Weight of each table entry
    function automatic logic [VALUE_W-1:0] roman_weight(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] w;
        case (idx)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // First character of each entry
    function automatic logic [SYMBOL_W-1:0] roman_first(input logic [IDX_W-1:0] idx);
        logic [SYMBOL_W-1:0] c;
        case (idx)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            4'd11:   c = CH_I;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    // Second character of a subtractive entry, none otherwise
    function automatic logic [SYMBOL_W-1:0] roman_second(input logic [IDX_W-1:0] idx);
        logic [SYMBOL_W-1:0] c;
        case (idx)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/int_to_roman_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Integer to Roman numeral encoder.
//
// Input: pulse i_start with i_value (12 bits) while o_busy is low; the
// transfer happens at that clock edge. Output: one ASCII character per
// o_strobe cycle on o_symbol, most significant symbol first, o_last on the
// final one. The receiver takes every strobed result and cannot stall.
//
// Out-of-range value (zero or above 3999): one result with symbol 0,
// o_last and o_bad_value set, in the cycle after the transfer; o_busy
// stays low, so a new item may follow at once.
//
// Valid value: a small sequencer walks a 13-entry greedy table (1000, 900,
// 500 ... 1) with one shared compare/subtract unit. Each cycle either emits
// a character and subtracts, or steps to the next entry; a subtractive
// pair subtracts its whole weight with its first character and steps to
// the next entry with its second. A numeral has at most 15 characters.
// o_busy falls in the cycle that shows the last character.
//
// Reset clears the sequencer and the strobe; no result is pending after it.
module int_to_roman_encoder_unit
    import roman_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [VALUE_W-1:0]   i_value,
    output logic                o_busy,
    output logic                o_strobe,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_bad_value
);

    t_state              r_state,  n_state;
    logic [VALUE_W-1:0]  r_rem,    n_rem;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic                r_strobe, n_strobe;
    logic [SYMBOL_W-1:0] r_symbol, n_symbol;
    logic                r_last,   n_last;
    logic                r_bad,    n_bad;

    // Shared compare/subtract unit
    logic [VALUE_W-1:0]  weight;
    logic [VALUE_W-1:0]  diff;
    logic                fits;
    logic                in_bad;

    assign weight = roman_weight(r_idx);
    assign fits   = (r_rem >= weight);
    assign diff   = r_rem - weight;
    assign in_bad = (i_value == '0) || (i_value > MAX_VALUE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_idx    <= n_idx;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_bad    <= n_bad;
    end

    // Sequencer: next state and results
    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_symbol = r_symbol;
        n_last   = r_last;
        n_bad    = r_bad;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (in_bad) begin
                        n_strobe = 1'b1;
                        n_symbol = CH_NONE;
                        n_last   = 1'b1;
                        n_bad    = 1'b1;
                    end else begin
                        n_rem   = i_value;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (fits) begin
                    n_strobe = 1'b1;
                    n_symbol = roman_first(r_idx);
                    n_bad    = 1'b0;
                    n_rem    = diff;
                    if (roman_second(r_idx) != CH_NONE) begin
                        n_last  = 1'b0;
                        n_state = ST_SECOND;
                    end else begin
                        n_last = (diff == '0);
                        if (diff == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + {{(IDX_W-1){1'b0}}, 1'b1};
                end
            end
            ST_SECOND: begin
                // remainder already reduced by the whole pair
                n_strobe = 1'b1;
                n_symbol = roman_second(r_idx);
                n_bad    = 1'b0;
                n_last   = (r_rem == '0);
                n_idx    = r_idx + {{(IDX_W-1){1'b0}}, 1'b1};
                n_state  = (r_rem == '0) ? ST_IDLE : ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_bad_value = r_bad;

endmodule

`default_nettype wire

FILE: sv/int_to_roman_encoder_unit_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "int_to_roman_encoder_unit_defines.svh"

// Port-level checks on the encoder
module int_to_roman_encoder_unit_chk
    import roman_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_start,
    input wire [VALUE_W-1:0]  i_value,
    input wire                o_busy,
    input wire                o_strobe,
    input wire [SYMBOL_W-1:0] o_symbol,
    input wire                o_last,
    input wire                o_bad_value
);

    logic take_bad;
    logic take_good;
    logic sym_ok;
    logic bad_out;
    logic run_quiet;

    assign take_bad  = i_start && !o_busy && ((i_value == '0) || (i_value > MAX_VALUE));
    assign take_good = i_start && !o_busy && (i_value != '0) && (i_value <= MAX_VALUE);
    assign sym_ok    = (o_symbol == CH_I) || (o_symbol == CH_V) || (o_symbol == CH_X) ||
                       (o_symbol == CH_L) || (o_symbol == CH_C) || (o_symbol == CH_D) ||
                       (o_symbol == CH_M);

    // Single error result, idle sequencer
    assign bad_out   = o_strobe && o_bad_value && o_last && (o_symbol == CH_NONE) && !o_busy;
    // Numeral running, nothing shown yet
    assign run_quiet = o_busy && !o_strobe;

    // Out-of-range transfer gives one error result next cycle
    `ROMAN_ASSERT_NEXT(a_bad_result, i_clk, i_rst_n, take_bad, bad_out, "bad value not flagged")

    // Valid transfer starts a numeral: busy, no result yet
    `ROMAN_ASSERT_NEXT(a_good_start, i_clk, i_rst_n, take_good, run_quiet, "valid start missed")

    // Busy drops exactly with the final character
    `ROMAN_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !o_busy, "busy after last")
    `ROMAN_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, o_busy, "idle mid numeral")

    // Characters of a valid numeral are Roman symbols
    `ROMAN_ASSERT_NOW(a_symbol, i_clk, i_rst_n, o_strobe && !o_bad_value, sym_ok, "illegal symbol")

endmodule

bind int_to_roman_encoder_unit int_to_roman_encoder_unit_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .i_value     (i_value),
    .o_busy      (o_busy),
    .o_strobe    (o_strobe),
    .o_symbol    (o_symbol),
    .o_last      (o_last),
    .o_bad_value (o_bad_value)
);

`default_nettype wire
